// ----- hdl/rrc_pkg.sv -----
// Shared types, constants and the sine table builder for the rotated rectangle corner unit.
// Depends on nothing; every other file imports it.
`default_nettype none

package rrc_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int ROM_STEPS       = 1 << SINE_TABLE_BITS;
  localparam int ROM_ENTRIES     = ROM_STEPS + 1;
  localparam int IDX_W           = SINE_TABLE_BITS + 1;
  localparam int ROM_W           = 15;
  localparam logic [ROM_W-1:0] ROM_MAX = '1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 8;
  // (2n)(2n+1) for n = 1..8
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Pipeline depth in cells; occupancy counter width
  localparam int NUM_CELLS = 4;
  localparam int CNT_W     = $clog2(NUM_CELLS + 1);

  typedef logic [ROM_W-1:0] sine_rom_t [ROM_ENTRIES];

  // Payload held by every cell: a centre and four 32-bit working lanes
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [3:0][31:0]   lane;
  } slot_t;

  // Registered sine/cosine lookup, magnitude plus sign
  typedef struct packed {
    logic [ROM_W-1:0] sin_mag;
    logic             sin_neg;
    logic [ROM_W-1:0] cos_mag;
    logic             cos_neg;
  } trig_t;

  // One quarter-wave entry: Q2.30 angle, Taylor series through x^17, round half up
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned idx);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    int                 n;
    x    = (HALF_PI_Q30 * 64'(idx)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = ($unsigned(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[ROM_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    int        i;
    for (i = 0; i < ROM_ENTRIES; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rrc_cell.sv -----
// One pipeline cell: a valid bit and a payload slot, passed to the next cell each cycle unless stalled.
// Depends on rrc_pkg for slot_t.
`default_nettype none

module rrc_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rrc_pkg::slot_t in_data,
  output logic          in_stall,
  output logic          out_valid,
  output rrc_pkg::slot_t out_data,
  input  logic          out_stall
);
  import rrc_pkg::*;

  logic  valid;
  slot_t data;

  // Full and the downstream cell is not taking the beat
  assign in_stall  = valid && out_stall;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rrc_sine_rom.sv -----
// Quarter-wave sine table with two registered read ports (sine and cosine).
// Depends on rrc_pkg for the table builder and trig_t.
`default_nettype none

module rrc_sine_rom (
  input  logic          clk,
  input  logic          en,
  input  logic [15:0]   rotation,
  output rrc_pkg::trig_t trig
);
  import rrc_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [1:0]                 sin_quad;
  logic [1:0]                 cos_quad;
  logic [SINE_TABLE_BITS-1:0] phase;
  logic [IDX_W-1:0]           sin_idx;
  logic [IDX_W-1:0]           cos_idx;

  assign sin_quad = rotation[15:14];
  assign cos_quad = sin_quad + 2'd1;  // cos(r) = sin(r + quarter turn)
  assign phase    = rotation[13 -: SINE_TABLE_BITS];

  // Odd quadrants read the mirrored entry
  assign sin_idx = sin_quad[0] ? (IDX_W'(ROM_STEPS) - {1'b0, phase}) : {1'b0, phase};
  assign cos_idx = cos_quad[0] ? (IDX_W'(ROM_STEPS) - {1'b0, phase}) : {1'b0, phase};

  always_ff @(posedge clk) begin
    if (en) begin
      trig.sin_mag <= SINE_ROM[sin_idx];
      trig.cos_mag <= SINE_ROM[cos_idx];
      trig.sin_neg <= sin_quad[1];
      trig.cos_neg <= cos_quad[1];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rotated_rect_corners_unit.sv -----
// Rotated rectangle corners: four-cell pipeline (lookup, multiply, sum, corner add).
// Each input beat is registered in cells 0, 1, 2 and 3 in order before it leaves as a result beat.
// Throughput: one item per cycle; out_stall reaches in_stall in the same cycle once all four
// cells hold a beat, and empty cells absorb it before that.
// Reset clears the valid bit of every cell; the sine table is constant and needs no clearing.
// Depends on rrc_pkg, rrc_cell and rrc_sine_rom.
`default_nettype none

module rotated_rect_corners_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [14:0]        rect_width,
  input  logic [14:0]        rect_height,
  input  logic [15:0]        rotation,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] corner0_x,
  output logic signed [15:0] corner0_y,
  output logic signed [15:0] corner1_x,
  output logic signed [15:0] corner1_y,
  output logic signed [15:0] corner2_x,
  output logic signed [15:0] corner2_y,
  output logic signed [15:0] corner3_x,
  output logic signed [15:0] corner3_y
);
  import rrc_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic  valid_chain [NUM_CELLS+1];
  logic  stall_chain [NUM_CELLS+1];
  slot_t stage_d     [NUM_CELLS];
  slot_t stage_q     [NUM_CELLS];
  trig_t trig;
  logic  rom_en;
  logic  in_beat;
  logic  out_beat;

  assign valid_chain[0]         = in_valid;
  assign stall_chain[NUM_CELLS] = out_stall;
  assign in_stall               = rst || stall_chain[0];
  assign out_valid              = valid_chain[NUM_CELLS];
  assign in_beat                = in_valid && !in_stall;
  assign out_beat               = out_valid && !out_stall;
  assign rom_en                 = in_beat;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rrc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[i]),
      .in_data   (stage_d[i]),
      .in_stall  (stall_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_data  (stage_q[i]),
      .out_stall (stall_chain[i+1])
    );
  end

  // Sine/cosine read registers alongside the first cell
  rrc_sine_rom u_rom (
    .clk      (clk),
    .en       (rom_en),
    .rotation (rotation),
    .trig     (trig)
  );

  // Cell 0: capture the centre and the size
  always_comb begin
    stage_d[0]         = '0;
    stage_d[0].pos_x   = pos_x;
    stage_d[0].pos_y   = pos_y;
    stage_d[0].lane[0] = 32'(rect_width);
    stage_d[0].lane[1] = 32'(rect_height);
  end

  // Cell 1: the four size-by-trig products
  logic signed [15:0] sin_v;
  logic signed [15:0] cos_v;
  logic signed [15:0] w_v;
  logic signed [15:0] h_v;

  always_comb begin
    sin_v = trig.sin_neg ? -$signed({1'b0, trig.sin_mag}) : $signed({1'b0, trig.sin_mag});
    cos_v = trig.cos_neg ? -$signed({1'b0, trig.cos_mag}) : $signed({1'b0, trig.cos_mag});
    w_v   = $signed({1'b0, stage_q[0].lane[0][14:0]});
    h_v   = $signed({1'b0, stage_q[0].lane[1][14:0]});
    stage_d[1]         = '0;
    stage_d[1].pos_x   = stage_q[0].pos_x;
    stage_d[1].pos_y   = stage_q[0].pos_y;
    stage_d[1].lane[0] = 32'(w_v) * 32'(cos_v);
    stage_d[1].lane[1] = 32'(h_v) * 32'(sin_v);
    stage_d[1].lane[2] = 32'(h_v) * 32'(cos_v);
    stage_d[1].lane[3] = 32'(w_v) * 32'(sin_v);
  end

  // Cell 2: a, b, c, d; the arithmetic shift floors by 2^16 (Q15 and the halving)
  logic signed [31:0] p_wk;
  logic signed [31:0] p_hs;
  logic signed [31:0] p_hk;
  logic signed [31:0] p_ws;

  always_comb begin
    p_wk = $signed(stage_q[1].lane[0]);
    p_hs = $signed(stage_q[1].lane[1]);
    p_hk = $signed(stage_q[1].lane[2]);
    p_ws = $signed(stage_q[1].lane[3]);
    stage_d[2]         = '0;
    stage_d[2].pos_x   = stage_q[1].pos_x;
    stage_d[2].pos_y   = stage_q[1].pos_y;
    stage_d[2].lane[0] = (p_wk + p_hs) >>> 16;
    stage_d[2].lane[1] = (p_hk - p_ws) >>> 16;
    stage_d[2].lane[2] = (p_hs - p_wk) >>> 16;
    stage_d[2].lane[3] = (p_hk + p_ws) >>> 16;
  end

  // Cell 3: corners, each lane packs {x, y}
  logic signed [16:0] px_e;
  logic signed [16:0] py_e;
  logic signed [16:0] ta;
  logic signed [16:0] tb;
  logic signed [16:0] tc;
  logic signed [16:0] td;

  always_comb begin
    px_e = {stage_q[2].pos_x[15], stage_q[2].pos_x};
    py_e = {stage_q[2].pos_y[15], stage_q[2].pos_y};
    ta   = $signed({stage_q[2].lane[0][15], stage_q[2].lane[0][15:0]});
    tb   = $signed({stage_q[2].lane[1][15], stage_q[2].lane[1][15:0]});
    tc   = $signed({stage_q[2].lane[2][15], stage_q[2].lane[2][15:0]});
    td   = $signed({stage_q[2].lane[3][15], stage_q[2].lane[3][15:0]});
    stage_d[3]         = '0;
    stage_d[3].lane[0] = {sat16(px_e - ta), sat16(py_e - tb)};
    stage_d[3].lane[1] = {sat16(px_e - tc), sat16(py_e - td)};
    stage_d[3].lane[2] = {sat16(px_e + tc), sat16(py_e + td)};
    stage_d[3].lane[3] = {sat16(px_e + ta), sat16(py_e + tb)};
  end

  assign corner0_x = stage_q[NUM_CELLS-1].lane[0][31:16];
  assign corner0_y = stage_q[NUM_CELLS-1].lane[0][15:0];
  assign corner1_x = stage_q[NUM_CELLS-1].lane[1][31:16];
  assign corner1_y = stage_q[NUM_CELLS-1].lane[1][15:0];
  assign corner2_x = stage_q[NUM_CELLS-1].lane[2][31:16];
  assign corner2_y = stage_q[NUM_CELLS-1].lane[2][15:0];
  assign corner3_x = stage_q[NUM_CELLS-1].lane[3][31:16];
  assign corner3_y = stage_q[NUM_CELLS-1].lane[3][15:0];

  // Items in flight, for the checks below
  logic [CNT_W-1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_beat) - CNT_W'(out_beat);
    end
  end

  a_out_has_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result beat with no item in flight");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output is moving");

  a_stall_count: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> inflight == CNT_W'(NUM_CELLS))
    else $error("input stalled with a free cell");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    in_beat && rotation == 16'd0 |=>
      trig.cos_mag == ROM_MAX && trig.sin_mag == '0 && !trig.cos_neg)
    else $error("zero rotation lookup wrong");

endmodule

`default_nettype wire
